### hw/rtl/jep_pkg.sv
package jep_pkg;

    // Default configuration
    localparam int POOL_DEPTH_DEF  = 1024;
    localparam int WORD_BITS_DEF   = 32;
    localparam int PARITY_TAPS_DEF = 5;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EXEC
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;   // latch input fields, launch pool read
        logic execute;   // apply the transaction, load result registers
    } dp_cmd_t;

endpackage

### hw/rtl/jep_ctrl.sv
module jep_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    output logic             done,
    output jep_pkg::dp_cmd_t cmd
);
    import jep_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        busy        = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                busy        = 1'b1;
                cmd.execute = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        // result registers load at the end of EXEC, strobe follows
        done_next = cmd.execute;
    end

    assign done = done_reg;

`ifndef SYNTHESIS
    a_exec_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EXEC |=> state_reg == ST_IDLE)
        else $error("EXEC lasted more than one cycle");

    a_capture_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> busy && !done)
        else $error("accepted transaction did not enter EXEC");

    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while still busy");
`endif

endmodule

### hw/rtl/jep_datapath.sv
module jep_datapath #(
    parameter int POOL_DEPTH  = jep_pkg::POOL_DEPTH_DEF,
    parameter int WORD_BITS   = jep_pkg::WORD_BITS_DEF,
    parameter int PARITY_TAPS = jep_pkg::PARITY_TAPS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  jep_pkg::dp_cmd_t              cmd,
    input  logic                          operation,
    input  logic [PARITY_TAPS-1:0]        timer_low_bits,
    output logic [WORD_BITS-1:0]          random_word,
    output logic                          pool_empty,
    output logic [$clog2(POOL_DEPTH)-1:0] pool_level,
    output logic                          word_added
);
    import jep_pkg::*;

    localparam int AW = $clog2(POOL_DEPTH);
    localparam int CW = $clog2(WORD_BITS);
    localparam logic [AW-1:0] LAST_IDX = AW'(POOL_DEPTH - 1);
    localparam logic [CW-1:0] LAST_BIT = CW'(WORD_BITS - 1);

    // pool memory, synchronous read
    logic [WORD_BITS-1:0] mem [POOL_DEPTH];
    logic [WORD_BITS-1:0] rd_data_reg;
    logic [AW-1:0]        rd_addr;
    logic                 mem_we;
    logic [WORD_BITS-1:0] mem_wdata;

    // captured transaction
    logic                   op_reg;
    logic [PARITY_TAPS-1:0] taps_reg;

    // harvest state
    logic [WORD_BITS-1:0] acc_reg, acc_next;
    logic [CW-1:0]        count_reg, count_next;

    // pointers; wrapped marks that every entry has been written once
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0] fill_reg, fill_next;
    logic          wrapped_reg, wrapped_next;

    // result registers
    logic [WORD_BITS-1:0] word_reg, word_next;
    logic                 empty_reg, empty_next;
    logic [AW-1:0]        level_reg, level_next;
    logic                 added_reg, added_next;

    logic                 parity;
    logic [WORD_BITS-1:0] acc_shift;
    logic                 last_bit;
    logic [AW-1:0]        wr_inc;
    logic [AW-1:0]        rd_inc;
    logic [WORD_BITS-1:0] old_entry;
    logic                 is_empty;

    assign rd_addr = operation ? rd_ptr_reg : wr_ptr_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_ptr_reg] <= mem_wdata;
        end
        if (cmd.capture)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= operation;
            taps_reg <= timer_low_bits;
        end
    end

    assign parity    = ^taps_reg;
    assign acc_shift = {acc_reg[WORD_BITS-2:0], parity};
    assign last_bit  = (count_reg == LAST_BIT);
    assign wr_inc    = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_inc    = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
    // an entry never written reads as zero (the memory itself is not reset)
    assign old_entry = wrapped_reg ? rd_data_reg : '0;
    assign is_empty  = (fill_reg == '0);

    always_comb
    begin
        acc_next     = acc_reg;
        count_next   = count_reg;
        wr_ptr_next  = wr_ptr_reg;
        rd_ptr_next  = rd_ptr_reg;
        fill_next    = fill_reg;
        wrapped_next = wrapped_reg;
        word_next    = word_reg;
        empty_next   = empty_reg;
        level_next   = level_reg;
        added_next   = added_reg;
        mem_we       = 1'b0;
        mem_wdata    = old_entry ^ acc_shift;

        if (cmd.execute)
        begin
            word_next  = '0;
            empty_next = 1'b0;
            added_next = 1'b0;
            if (!op_reg)
            begin
                acc_next = acc_shift;
                if (last_bit)
                begin
                    count_next  = '0;
                    mem_we      = 1'b1;
                    added_next  = 1'b1;
                    wr_ptr_next = wr_inc;
                    if (wr_ptr_reg == LAST_IDX)
                    begin
                        wrapped_next = 1'b1;
                    end
                    // head caught the tail: drop the oldest word
                    if (wr_inc == rd_ptr_reg)
                    begin
                        rd_ptr_next = rd_inc;
                    end
                    else
                    begin
                        fill_next = fill_reg + 1'b1;
                    end
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            else
            begin
                if (is_empty)
                begin
                    empty_next = 1'b1;
                end
                else
                begin
                    word_next   = rd_data_reg;
                    rd_ptr_next = rd_inc;
                    fill_next   = fill_reg - 1'b1;
                end
            end
            level_next = fill_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg     <= '0;
            count_reg   <= '0;
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            fill_reg    <= '0;
            wrapped_reg <= 1'b0;
            word_reg    <= '0;
            empty_reg   <= 1'b0;
            level_reg   <= '0;
            added_reg   <= 1'b0;
        end
        else
        begin
            acc_reg     <= acc_next;
            count_reg   <= count_next;
            wr_ptr_reg  <= wr_ptr_next;
            rd_ptr_reg  <= rd_ptr_next;
            fill_reg    <= fill_next;
            wrapped_reg <= wrapped_next;
            word_reg    <= word_next;
            empty_reg   <= empty_next;
            level_reg   <= level_next;
            added_reg   <= added_next;
        end
    end

    assign random_word = word_reg;
    assign pool_empty  = empty_reg;
    assign pool_level  = level_reg;
    assign word_added  = added_reg;

`ifndef SYNTHESIS
    logic [AW:0] occupancy;
    assign occupancy = (wr_ptr_reg >= rd_ptr_reg)
        ? ({1'b0, wr_ptr_reg} - {1'b0, rd_ptr_reg})
        : ({1'b0, wr_ptr_reg} + (AW+1)'(POOL_DEPTH) - {1'b0, rd_ptr_reg});

    a_fill_matches_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg == occupancy[AW-1:0])
        else $error("fill level disagrees with pointer distance");

    a_no_pass_before_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        !wrapped_reg |-> rd_ptr_reg <= wr_ptr_reg)
        else $error("tail passed head before first wrap");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        empty_reg |-> (word_reg == '0) && !added_reg)
        else $error("empty read returned data or a sample flag");
`endif

endmodule

### hw/rtl/jitter_entropy_pool_fifo_core.sv
// Timer-jitter entropy pool with a word FIFO.
//
// Input channel: a transaction is taken at a rising edge with start high
// and busy low. operation 0 is a sample tick: the parity of timer_low_bits
// is shifted into a word accumulator, and each full word is XORed into the
// pool entry at the head. operation 1 reads the oldest pool word.
// Result channel: done is high for exactly one cycle with random_word,
// pool_empty, pool_level and word_added; the receiver cannot stall it.
// Timing: accept cycle (pool memory read launched), then EXEC
// (read-modify-write of the pool, pointer update), result strobe on the
// following cycle. busy is high only during EXEC, so a new transaction can
// be accepted in the same cycle the previous result is shown.
// When full, a new word drops the oldest one and the level stays put; the
// pool holds at most POOL_DEPTH-1 words.
// Reset: pointers, level and bit count clear at once; the pool reads as
// zero until each entry is first written, so no clearing pass is needed
// and the block can accept a transaction as soon as reset is released.
module jitter_entropy_pool_fifo_core #(
    parameter int POOL_DEPTH  = jep_pkg::POOL_DEPTH_DEF,
    parameter int WORD_BITS   = jep_pkg::WORD_BITS_DEF,
    parameter int PARITY_TAPS = jep_pkg::PARITY_TAPS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          operation,
    input  logic [PARITY_TAPS-1:0]        timer_low_bits,
    output logic                          done,
    output logic [WORD_BITS-1:0]          random_word,
    output logic                          pool_empty,
    output logic [$clog2(POOL_DEPTH)-1:0] pool_level,
    output logic                          word_added
);
    import jep_pkg::*;

    // controller -> datapath commands
    dp_cmd_t cmd;

    // sequences accept and execute cycles, drives busy and done
    jep_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    // accumulator, pool memory, pointers and result registers
    jep_datapath #(
        .POOL_DEPTH  (POOL_DEPTH),
        .WORD_BITS   (WORD_BITS),
        .PARITY_TAPS (PARITY_TAPS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .operation      (operation),
        .timer_low_bits (timer_low_bits),
        .random_word    (random_word),
        .pool_empty     (pool_empty),
        .pool_level     (pool_level),
        .word_added     (word_added)
    );

endmodule
